[hw/rtl/kct_pkg.sv]
`default_nettype none

package kct_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_MUX   = 3'd1,
        OP_KEY   = 3'd2,
        OP_START = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KIND_DIGIT    = 3'd0,
        KIND_EQUALS   = 3'd1,
        KIND_SUM      = 3'd2,
        KIND_SUB      = 3'd3,
        KIND_MULT     = 3'd4,
        KIND_DIVIDE   = 3'd5,
        KIND_ON_CLEAR = 3'd6,
        KIND_UNKNOWN  = 3'd7
    } kind_t;

    localparam logic [7:0] LOCKOUT_RESET = 8'd6;
    localparam logic [7:0] SEG_DP        = 8'h80;
    localparam int unsigned BCD_DIGITS   = 3;

    typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
    } key_info_t;

    typedef struct packed {
        logic [7:0] segments;
        logic [2:0] digit_select;
        logic       done_led;
        logic       running;
        logic [9:0] remaining_tenths;
        logic [9:0] entered_tenths;
        kind_t      key_kind;
    } result_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] value);
        logic [7:0] pattern;
        case (value)
            4'd0: pattern = 8'h3F;
            4'd1: pattern = 8'h06;
            4'd2: pattern = 8'h5B;
            4'd3: pattern = 8'h4F;
            4'd4: pattern = 8'h66;
            4'd5: pattern = 8'h6D;
            4'd6: pattern = 8'h7D;
            4'd7: pattern = 8'h07;
            4'd8: pattern = 8'h7F;
            4'd9: pattern = 8'h6F;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/keypad_countdown_timer_7seg.sv]
`default_nettype none

// Keypad countdown timer with a multiplexed 7-segment display. Each item is
// taken into the input register and its result is then loaded into the output
// register; the block sustains one item per cycle as long as m_ready is high.
// The whole state update for an item is done in one pass of logic between
// those registers. Items are ticks of 10 ms, display mux ticks, key presses,
// start and clear; every item yields exactly one result showing the state
// after it. The remaining time is kept both as a binary tenths count and as
// decimal digits, so no division is needed for the display. Write
// lockout_ticks only while no item is in flight.
module keypad_countdown_timer_7seg #(
    parameter int DISPLAY_DIGITS = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_operation,
    input  wire logic [7:0]  s_key_code,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_segments,
    output logic [2:0]       m_digit_select,
    output logic             m_done_led,
    output logic             m_running,
    output logic [9:0]       m_remaining_tenths,
    output logic [9:0]       m_entered_tenths,
    output logic [2:0]       m_key_kind,

    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);
    import kct_pkg::*;

    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [7:0] code_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result;
    logic       advance;
    logic       fire;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    kct_core #(
        .DISPLAY_DIGITS (DISPLAY_DIGITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .operation   (op_reg),
        .key_code    (code_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            code_reg <= s_key_code;
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_segments         = out_reg.segments;
    assign m_digit_select     = out_reg.digit_select;
    assign m_done_led         = out_reg.done_led;
    assign m_running          = out_reg.running;
    assign m_remaining_tenths = out_reg.remaining_tenths;
    assign m_entered_tenths   = out_reg.entered_tenths;
    assign m_key_kind         = out_reg.key_kind;

endmodule

`default_nettype wire

[hw/rtl/kct_keypad.sv]
`default_nettype none

module kct_keypad (
    input  wire logic [7:0]        key_code,
    output kct_pkg::key_info_t     key_info
);
    import kct_pkg::*;

    // scan codes: row nibble low, column nibble high (active-low lines)
    localparam logic [7:0] SC_ON_CLEAR = 8'd231;
    localparam logic [7:0] SC_0        = 8'd215;
    localparam logic [7:0] SC_EQUALS   = 8'd183;
    localparam logic [7:0] SC_SUM      = 8'd119;
    localparam logic [7:0] SC_1        = 8'd235;
    localparam logic [7:0] SC_2        = 8'd219;
    localparam logic [7:0] SC_3        = 8'd187;
    localparam logic [7:0] SC_SUB      = 8'd123;
    localparam logic [7:0] SC_4        = 8'd237;
    localparam logic [7:0] SC_5        = 8'd221;
    localparam logic [7:0] SC_6        = 8'd189;
    localparam logic [7:0] SC_MULT     = 8'd125;
    localparam logic [7:0] SC_7        = 8'd238;
    localparam logic [7:0] SC_8        = 8'd222;
    localparam logic [7:0] SC_9        = 8'd190;
    localparam logic [7:0] SC_DIVIDE   = 8'd126;

    always_comb begin
        key_info.kind  = KIND_DIGIT;
        key_info.digit = 4'd0;
        case (key_code)
            SC_ON_CLEAR: key_info.kind = KIND_ON_CLEAR;
            SC_0:        key_info.digit = 4'd0;
            SC_EQUALS:   key_info.kind = KIND_EQUALS;
            SC_SUM:      key_info.kind = KIND_SUM;
            SC_1:        key_info.digit = 4'd1;
            SC_2:        key_info.digit = 4'd2;
            SC_3:        key_info.digit = 4'd3;
            SC_SUB:      key_info.kind = KIND_SUB;
            SC_4:        key_info.digit = 4'd4;
            SC_5:        key_info.digit = 4'd5;
            SC_6:        key_info.digit = 4'd6;
            SC_MULT:     key_info.kind = KIND_MULT;
            SC_7:        key_info.digit = 4'd7;
            SC_8:        key_info.digit = 4'd8;
            SC_9:        key_info.digit = 4'd9;
            SC_DIVIDE:   key_info.kind = KIND_DIVIDE;
            default:     key_info.kind = KIND_UNKNOWN;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/kct_core.sv]
`default_nettype none

module kct_core #(
    parameter int DISPLAY_DIGITS = 3
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire logic [2:0]        operation,
    input  wire logic [7:0]        key_code,
    input  wire logic              cfg_wr_en,
    input  wire logic [7:0]        cfg_wr_data,
    output kct_pkg::result_t       result
);
    import kct_pkg::*;

    localparam int MUX_W = (DISPLAY_DIGITS > 1) ? $clog2(DISPLAY_DIGITS) : 1;

    key_info_t        key_info;

    logic [7:0]       lockout_ticks_reg;
    logic [9:0]       dur_reg, dur_next;
    bcd_t             dur_bcd_reg, dur_bcd_next;
    logic [1:0]       digits_reg, digits_next;
    logic             counting_reg, counting_next;
    logic             led_reg, led_next;
    logic [7:0]       lock_reg, lock_next;
    logic [MUX_W-1:0] mux_reg, mux_next;
    logic [9:0]       rem_reg, rem_next;
    bcd_t             rem_bcd_reg, rem_bcd_next;
    logic [3:0]       hund_reg, hund_next;

    logic [2:0]       idx;
    logic [3:0]       idx_inc;
    logic [7:0]       sel_full;
    logic [3:0]       shown;
    logic [13:0]      dur_sum;
    logic [13:0]      dur_x10;

    kct_keypad u_keypad (
        .key_code (key_code),
        .key_info (key_info)
    );

    assign idx      = 3'(mux_reg);
    assign idx_inc  = {1'b0, idx} + 4'd1;
    assign sel_full = 8'd1 << idx;
    assign dur_sum  = 14'(dur_reg) + 14'(key_info.digit);
    assign dur_x10  = (dur_sum << 3) + (dur_sum << 1);

    always_comb begin
        case (idx)
            3'd0:    shown = rem_bcd_reg[0];
            3'd1:    shown = rem_bcd_reg[1];
            3'd2:    shown = rem_bcd_reg[2];
            default: shown = 4'd0;
        endcase
    end

    always_comb begin
        dur_next      = dur_reg;
        dur_bcd_next  = dur_bcd_reg;
        digits_next   = digits_reg;
        counting_next = counting_reg;
        led_next      = led_reg;
        lock_next     = lock_reg;
        mux_next      = mux_reg;
        rem_next      = rem_reg;
        rem_bcd_next  = rem_bcd_reg;
        hund_next     = hund_reg;

        result.segments     = 8'd0;
        result.digit_select = 3'd0;
        result.key_kind     = KIND_UNKNOWN;

        case (operation)
            OP_TICK: begin
                if (lock_reg != 8'd0) begin
                    lock_next = lock_reg - 8'd1;
                end
                if (counting_reg && !(rem_reg == 10'd0 && hund_reg == 4'd0)) begin
                    if (hund_reg != 4'd0) begin
                        hund_next = hund_reg - 4'd1;
                    end else begin
                        // borrow from the tenths count, binary and decimal alike
                        hund_next = 4'd9;
                        rem_next  = rem_reg - 10'd1;
                        if (rem_bcd_reg[0] != 4'd0) begin
                            rem_bcd_next[0] = rem_bcd_reg[0] - 4'd1;
                        end else begin
                            rem_bcd_next[0] = 4'd9;
                            if (rem_bcd_reg[1] != 4'd0) begin
                                rem_bcd_next[1] = rem_bcd_reg[1] - 4'd1;
                            end else begin
                                rem_bcd_next[1] = 4'd9;
                                rem_bcd_next[2] = rem_bcd_reg[2] - 4'd1;
                            end
                        end
                    end
                end
                if (counting_reg && rem_next == 10'd0 && hund_next == 4'd0) begin
                    counting_next = 1'b0;
                    led_next      = 1'b1;
                end
            end
            OP_MUX: begin
                if (counting_reg) begin
                    result.segments     = seg_pattern(shown) | ((idx == 3'd1) ? SEG_DP : 8'd0);
                    result.digit_select = sel_full[2:0];
                    mux_next = (idx_inc >= 4'(DISPLAY_DIGITS)) ? '0 : MUX_W'(idx_inc);
                end
            end
            OP_KEY: begin
                result.key_kind = key_info.kind;
                if (lock_reg == 8'd0) begin
                    lock_next = lockout_ticks_reg;
                    if (!counting_reg && key_info.kind == KIND_DIGIT && digits_reg != 2'd3) begin
                        if (digits_reg != 2'd2) begin
                            // seconds digit: shift in, tenths stays zero
                            dur_next        = dur_x10[9:0];
                            dur_bcd_next[2] = dur_bcd_reg[1];
                            dur_bcd_next[1] = key_info.digit;
                            dur_bcd_next[0] = 4'd0;
                        end else begin
                            dur_next        = dur_sum[9:0];
                            dur_bcd_next[0] = key_info.digit;
                        end
                        digits_next = digits_reg + 2'd1;
                    end
                end
            end
            OP_START: begin
                if (lock_reg == 8'd0) begin
                    lock_next = lockout_ticks_reg;
                    if (!counting_reg) begin
                        hund_next = 4'd0;
                        if (dur_reg == 10'd0) begin
                            rem_next     = 10'd0;
                            rem_bcd_next = '0;
                            led_next     = 1'b1;
                        end else begin
                            rem_next      = dur_reg;
                            rem_bcd_next  = dur_bcd_reg;
                            counting_next = 1'b1;
                            mux_next      = '0;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                if (lock_reg == 8'd0) begin
                    lock_next     = lockout_ticks_reg;
                    dur_next      = 10'd0;
                    dur_bcd_next  = '0;
                    digits_next   = 2'd0;
                    counting_next = 1'b0;
                    led_next      = 1'b0;
                    mux_next      = '0;
                    rem_next      = 10'd0;
                    rem_bcd_next  = '0;
                    hund_next     = 4'd0;
                end
            end
            default: begin
            end
        endcase

        result.done_led         = led_next;
        result.running          = counting_next;
        result.remaining_tenths = rem_next;
        result.entered_tenths   = dur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lockout_ticks_reg <= LOCKOUT_RESET;
            dur_reg           <= 10'd0;
            dur_bcd_reg       <= '0;
            digits_reg        <= 2'd0;
            counting_reg      <= 1'b0;
            led_reg           <= 1'b0;
            lock_reg          <= 8'd0;
            mux_reg           <= '0;
            rem_reg           <= 10'd0;
            rem_bcd_reg       <= '0;
            hund_reg          <= 4'd0;
        end else begin
            if (cfg_wr_en) begin
                lockout_ticks_reg <= cfg_wr_data;
            end
            if (fire) begin
                dur_reg      <= dur_next;
                dur_bcd_reg  <= dur_bcd_next;
                digits_reg   <= digits_next;
                counting_reg <= counting_next;
                led_reg      <= led_next;
                lock_reg     <= lock_next;
                mux_reg      <= mux_next;
                rem_reg      <= rem_next;
                rem_bcd_reg  <= rem_bcd_next;
                hund_reg     <= hund_next;
            end
        end
    end

    a_counting_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        counting_reg |-> (rem_reg != 10'd0 || hund_reg != 4'd0))
        else $error("countdown running at zero");

    a_rem_bcd_match: assert property (@(posedge aclk) disable iff (!aresetn)
        14'(rem_reg) == 14'(rem_bcd_reg[2]) * 14'd100 + 14'(rem_bcd_reg[1]) * 14'd10
                        + 14'(rem_bcd_reg[0]))
        else $error("remaining time digits disagree with binary count");

    a_dur_bcd_match: assert property (@(posedge aclk) disable iff (!aresetn)
        14'(dur_reg) == 14'(dur_bcd_reg[2]) * 14'd100 + 14'(dur_bcd_reg[1]) * 14'd10
                        + 14'(dur_bcd_reg[0]))
        else $error("duration digits disagree with binary duration");

    a_no_digits_no_duration: assert property (@(posedge aclk) disable iff (!aresetn)
        (digits_reg == 2'd0) |-> (dur_reg == 10'd0))
        else $error("duration set with no digits entered");

    a_hund_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hund_reg <= 4'd9)
        else $error("hundredths digit out of range");

endmodule

`default_nettype wire
